@@ rtl/fifo_with_keyed_removal_top_defines.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef FIFO_WITH_KEYED_REMOVAL_TOP_DEFINES_SVH
`define FIFO_WITH_KEYED_REMOVAL_TOP_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define FWKR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define FWKR_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

@@ rtl/fwkr_pkg.sv @@
`default_nettype none

package fwkr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_DEQ = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] client_code;
        logic [15:0] item_number;
        logic [31:0] payload_handle;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_client;
        logic [15:0] out_item;
        logic [31:0] out_payload;
        logic [4:0]  removed_count;
    } t_out;

    typedef struct packed {
        logic [15:0] client;
        logic [15:0] item;
        logic [31:0] payload;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_DEL
    } t_state;

endpackage

`default_nettype wire

@@ rtl/fwkr_mem.sv @@
`default_nettype none

module fwkr_mem
    import fwkr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(QUEUE_DEPTH_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/fifo_with_keyed_removal_top.sv @@
// Enqueue: result registered straight from the beat. Dequeue: registered memory read, then result
// register; an empty queue registers its result directly. Delete: walks the stored entries, one
// entry read and compacted per cycle via the single read port and single write port of the memory.
// Next beat is taken once the current result is registered and the output is free.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
`default_nettype none
`include "fifo_with_keyed_removal_top_defines.svh"

module fifo_with_keyed_removal_top
    import fwkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(a) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_chk, n_chk;
    logic [CW-1:0] r_keep, n_keep;
    logic [CW-1:0] r_removed, n_removed;
    logic [15:0]   r_key_client, n_key_client;
    logic [15:0]   r_key_item, n_key_item;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic          in_acc;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    t_entry        mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    t_entry        mem_rd_data;
    logic          key_hit;

    fwkr_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign key_hit     = (mem_rd_data.client == r_key_client) &&
                         (mem_rd_data.item == r_key_item);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_chk        = r_chk;
        n_keep       = r_keep;
        n_removed    = r_removed;
        n_key_client = r_key_client;
        n_key_item   = r_key_item;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = wrap_add(r_head, r_count);
        mem_wr_data  = '{client: i_in_data.client_code, item: i_in_data.item_number,
                         payload: i_in_data.payload_handle};
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_head;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out = '0;
                    case (i_in_data.mode)
                        MODE_ENQ: begin
                            n_out_valid = 1'b1;
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                mem_wr_en    = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_out.status = STAT_OK;
                            end
                        end
                        MODE_DEQ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end else begin
                                mem_rd_en = 1'b1;
                                n_state   = ST_RD;
                            end
                        end
                        MODE_DEL: begin
                            n_key_client = i_in_data.client_code;
                            n_key_item   = i_in_data.item_number;
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STAT_NO_MATCH;
                            end else begin
                                mem_rd_en = 1'b1;
                                n_chk     = '0;
                                n_keep    = '0;
                                n_removed = '0;
                                n_state   = ST_DEL;
                            end
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = STAT_OK;
                n_out.out_client  = mem_rd_data.client;
                n_out.out_item    = mem_rd_data.item;
                n_out.out_payload = mem_rd_data.payload;
                n_head            = wrap_add(r_head, CW'(1));
                n_count           = r_count - CW'(1);
                n_state           = ST_IDLE;
            end
            ST_DEL: begin
                if (key_hit) begin
                    n_removed = r_removed + CW'(1);
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = wrap_add(r_head, r_keep);
                    mem_wr_data = mem_rd_data;
                    n_keep      = r_keep + CW'(1);
                end
                if (r_chk != r_count - CW'(1)) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = wrap_add(r_head, r_chk + CW'(1));
                    n_chk       = r_chk + CW'(1);
                end else begin
                    n_count      = n_keep;
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.status = (n_removed == '0) ? STAT_NO_MATCH : STAT_OK;
                    if (32'(n_removed) > 32'd31) begin
                        n_out.removed_count = 5'd31;
                    end else begin
                        n_out.removed_count = 5'(n_removed);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_chk       <= '0;
            r_keep      <= '0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_keep      <= n_keep;
            r_removed   <= n_removed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_client <= n_key_client;
        r_key_item   <= n_key_item;
        r_out        <= n_out;
    end

    `FWKR_ASSERT(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "entry count above depth")
    `FWKR_ASSERT(a_del_tally, (r_state != ST_DEL) || (r_keep + r_removed == r_chk),
        "delete tally out of step with walk")
    `FWKR_ASSERT_NEXT(a_rd_result, r_state == ST_RD, r_out_valid && r_state == ST_IDLE,
        "dequeue read did not produce a result")
    `FWKR_ASSERT_NEXT(a_del_nonempty, in_acc && i_in_data.mode == MODE_DEL && r_count != '0,
        r_state == ST_DEL, "delete walk not started")

endmodule

`default_nettype wire

@@ bench/fwkr_checker.sv @@
`timescale 1ns / 1ps

module fwkr_checker
    import fwkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_full_seen,
    output int   o_empty_seen,
    output int   o_no_match_seen,
    output int   o_removed_total
);

    t_entry stored_q[$];
    t_out   result_q[$];
    int     fail_count    = 0;
    int     pending_count = 0;
    int     full_seen     = 0;
    int     empty_seen    = 0;
    int     no_match_seen = 0;
    int     removed_total = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_full_seen     = full_seen;
    assign o_empty_seen    = empty_seen;
    assign o_no_match_seen = no_match_seen;
    assign o_removed_total = removed_total;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic t_out queue_op_result(input t_in b);
        t_out   r;
        t_entry e;
        t_entry survivors[$];
        int     removed;
        r = '0;
        removed = 0;
        case (b.mode)
            MODE_ENQ: begin
                if (stored_q.size() >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    e.client  = b.client_code;
                    e.item    = b.item_number;
                    e.payload = b.payload_handle;
                    stored_q.push_back(e);
                end
            end
            MODE_DEQ: begin
                if (stored_q.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    e = stored_q.pop_front();
                    r.out_client  = e.client;
                    r.out_item    = e.item;
                    r.out_payload = e.payload;
                end
            end
            MODE_DEL: begin
                foreach (stored_q[k]) begin
                    if (stored_q[k].client == b.client_code &&
                        stored_q[k].item == b.item_number) begin
                        removed++;
                    end else begin
                        survivors.push_back(stored_q[k]);
                    end
                end
                stored_q = survivors;
                if (removed == 0) begin
                    r.status = STAT_NO_MATCH;
                end
                r.removed_count = (removed > 31) ? 5'd31 : removed[4:0];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            stored_q.delete();
            result_q.delete();
            pending_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(queue_op_result(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (result_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", got.status, 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.out_client !== want.out_client)
                        report_mismatch("out_client", got.out_client, want.out_client);
                    if (got.out_item !== want.out_item)
                        report_mismatch("out_item", got.out_item, want.out_item);
                    if (got.out_payload !== want.out_payload)
                        report_mismatch("out_payload", got.out_payload, want.out_payload);
                    if (got.removed_count !== want.removed_count)
                        report_mismatch("removed_count", got.removed_count,
                                        want.removed_count);
                    case (want.status)
                        STAT_FULL:     full_seen++;
                        STAT_EMPTY:    empty_seen++;
                        STAT_NO_MATCH: no_match_seen++;
                        default:       removed_total += want.removed_count;
                    endcase
                end
            end
            pending_count = result_q.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fwkr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BEATS = 900;
    localparam int HOLD_CYCLES  = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int fail_count;
    int pending;
    int full_seen;
    int empty_seen;
    int no_match_seen;
    int removed_total;

    int mode_sent[4];
    int burst_left = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int enq_pct;
    logic [15:0] client_pool[4];
    logic [15:0] item_pool[4];

    fifo_with_keyed_removal_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    fwkr_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_no_match_seen(no_match_seen),
        .o_removed_total(removed_total)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_left = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic t_in make_beat(input logic [1:0] mode, input logic [15:0] client,
                                      input logic [15:0] item, input logic [31:0] payload);
        t_in b;
        b.mode           = mode;
        b.client_code    = client;
        b.item_number    = item;
        b.payload_handle = payload;
        return b;
    endfunction

    function automatic t_in pick_beat(input int enq_share);
        int   roll;
        t_in  b;
        roll = $urandom_range(0, 99);
        b.client_code    = client_pool[$urandom_range(0, 3)];
        b.item_number    = item_pool[$urandom_range(0, 3)];
        b.payload_handle = $urandom();
        if (roll < 4) begin
            b.mode = MODE_UNUSED;
        end else if (roll < 10) begin
            b.mode        = 2'($urandom_range(0, 3));
            b.client_code = 16'($urandom());
            b.item_number = 16'($urandom());
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < enq_share)
                b.mode = MODE_ENQ;
            else if (roll - enq_share < (100 - enq_share) / 2)
                b.mode = MODE_DEQ;
            else
                b.mode = MODE_DEL;
        end
        return b;
    endfunction

    task automatic send_beat(input t_in b);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        mode_sent[b.mode]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_beat(make_beat(MODE_DEQ, 16'h0000, 16'h0000, 32'h0000_0000));
        send_beat(make_beat(MODE_DEL, 16'h0000, 16'h0000, 32'h0000_0000));
        send_beat(make_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
            send_beat(make_beat(MODE_ENQ, i[0] ? 16'hFFFF : 16'h0000,
                                i[1] ? 16'hFFFF : 16'h0000,
                                (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i)));
        end
        send_beat(make_beat(MODE_ENQ, 16'hA5A5, 16'h5A5A, 32'h1234_5678));
        send_beat(make_beat(MODE_DEL, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
        send_beat(make_beat(MODE_DEL, 16'h1234, 16'h5678, 32'hFFFF_FFFF));
        send_beat(make_beat(MODE_DEQ, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_beat(make_beat(MODE_DEL, 16'h0000, 16'h0000, 32'h0000_0000));
        send_beat(make_beat(MODE_DEQ, 16'h0000, 16'h0000, 32'h0000_0000));
        wait_all_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 60 == 0) begin
                for (int k = 0; k < 4; k++) begin
                    client_pool[k] = ($urandom_range(0, 4) == 0) ? {16{k[0]}}
                                                                 : 16'($urandom());
                    item_pool[k]   = ($urandom_range(0, 4) == 0) ? {16{k[1]}}
                                                                 : 16'($urandom());
                end
                case ($urandom_range(0, 3))
                    0: enq_pct = 25;
                    1: enq_pct = 45;
                    2: enq_pct = 60;
                    default: enq_pct = 80;
                endcase
            end
            if (n % 150 == 149) begin
                wait_all_results();
            end
            send_beat(pick_beat(enq_pct));
        end

        wait_all_results();
        repeat (HOLD_CYCLES) @(negedge clk);

        $display("sent %0d beats: %0d enqueue, %0d dequeue, %0d delete, %0d unused mode",
                 mode_sent[0] + mode_sent[1] + mode_sent[2] + mode_sent[3],
                 mode_sent[MODE_ENQ], mode_sent[MODE_DEQ], mode_sent[MODE_DEL],
                 mode_sent[MODE_UNUSED]);
        $display("saw %0d full, %0d empty, %0d unmatched deletes, %0d entries removed by key",
                 full_seen, empty_seen, no_match_seen, removed_total);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ fifo_with_keyed_removal_top.f @@
+incdir+rtl
rtl/fwkr_pkg.sv
rtl/fwkr_mem.sv
rtl/fifo_with_keyed_removal_top.sv
bench/fwkr_checker.sv
bench/tb_top.sv
